// ===== hdl/phct_pkg.sv =====
// ----------------------------------------------------------------------------
// phct_pkg
// Types and constants shared by the pulsed heat/chill thermostat.
// ----------------------------------------------------------------------------
`default_nettype none

package phct_pkg;

  localparam int PWM_PERIOD_MS = 100;
  localparam int PWM_W         = $clog2(PWM_PERIOD_MS);
  localparam int TIME_WIDTH    = 20;
  localparam int TEMP_W        = 12;
  localparam int TOL_W         = 8;
  localparam int PCT_W         = 7;
  localparam int CMP_W         = TEMP_W + 2;
  localparam int CFG_DATA_W    = 20;
  localparam int CFG_IDX_W     = 3;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  localparam logic signed [TEMP_W-1:0] SETPOINT_RST     = 12'sd320;
  localparam logic [TOL_W-1:0]         TOLERANCE_RST    = 8'd1;
  localparam logic [PCT_W-1:0]         HEAT_PCT_RST     = 7'd100;
  localparam logic [CFG_DATA_W-1:0]    HEAT_PULSE_RST   = 20'd10000;
  localparam logic [CFG_DATA_W-1:0]    HEAT_RECOV_RST   = 20'd120000;
  localparam logic [CFG_DATA_W-1:0]    CHILL_PULSE_RST  = 20'd1000;
  localparam logic [CFG_DATA_W-1:0]    CHILL_RECOV_RST  = 20'd60000;
  localparam logic [CFG_DATA_W-1:0]    QUIET_RST        = 20'd30000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT          = 3'd0,
    REG_TOLERANCE         = 3'd1,
    REG_HEAT_POWER_PCT    = 3'd2,
    REG_HEAT_PULSE_MS     = 3'd3,
    REG_HEAT_RECOVERY_MS  = 3'd4,
    REG_CHILL_PULSE_MS    = 3'd5,
    REG_CHILL_RECOVERY_MS = 3'd6,
    REG_INITIAL_QUIET_MS  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_LOCKOUT = 2'd1,
    MODE_HEAT    = 2'd2,
    MODE_CHILL   = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     temp_valid;
    logic                     safe_to_run;
  } req_t;

  typedef struct packed {
    logic       heater_drive;
    logic       chiller_drive;
    logic [1:0] mode;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/phct_core.sv =====
// ----------------------------------------------------------------------------
// phct_core
// Configuration registers, thermostat state and the per-tick update.
// ----------------------------------------------------------------------------
`default_nettype none

module phct_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [phct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [phct_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 step,
  input  wire phct_pkg::req_t                       req,
  output phct_pkg::rsp_t                            rsp
);

  logic signed [phct_pkg::TEMP_W-1:0]   setpoint;
  logic [phct_pkg::TOL_W-1:0]           tolerance;
  logic [phct_pkg::PCT_W-1:0]           heat_power_pct;
  logic [phct_pkg::TIME_WIDTH-1:0]      heat_pulse_ms;
  logic [phct_pkg::TIME_WIDTH-1:0]      heat_recovery_ms;
  logic [phct_pkg::TIME_WIDTH-1:0]      chill_pulse_ms;
  logic [phct_pkg::TIME_WIDTH-1:0]      chill_recovery_ms;

  logic                                 heating, heating_next;
  logic                                 chilling, chilling_next;
  logic [phct_pkg::TIME_WIDTH-1:0]      pulse_length, pulse_length_next;
  logic [phct_pkg::TIME_WIDTH-1:0]      recovery_length, recovery_length_next;
  logic [phct_pkg::TIME_WIDTH-1:0]      elapsed_ms, elapsed_ms_next;
  logic [phct_pkg::PWM_W-1:0]           pwm_phase, pwm_phase_next;
  logic                                 quiet_pending, quiet_pending_next;

  logic [phct_pkg::TIME_WIDTH-1:0]      elapsed_inc;
  logic [phct_pkg::PWM_W:0]             phase_inc;
  logic                                 running, locked, start, heat_start, chill_start, stop;
  logic signed [phct_pkg::CMP_W-1:0]    temp_x, lo_bound, hi_bound;
  phct_pkg::cfg_reg_t                   cfg_sel;

  assign cfg_sel = phct_pkg::cfg_reg_t'(cfg_index);

  always_comb begin
    elapsed_inc = (elapsed_ms == phct_pkg::TIME_MAX) ? elapsed_ms : elapsed_ms + 1'b1;
    phase_inc   = {1'b0, pwm_phase} + 1'b1;
    if (32'(phase_inc) >= phct_pkg::PWM_PERIOD_MS) begin
      pwm_phase_next = '0;
    end else begin
      pwm_phase_next = phase_inc[phct_pkg::PWM_W-1:0];
    end

    temp_x   = phct_pkg::CMP_W'(req.temperature);
    lo_bound = phct_pkg::CMP_W'(setpoint)
             - $signed({{(phct_pkg::CMP_W-phct_pkg::TOL_W){1'b0}}, tolerance});
    hi_bound = phct_pkg::CMP_W'(setpoint)
             + $signed({{(phct_pkg::CMP_W-phct_pkg::TOL_W){1'b0}}, tolerance});

    running     = heating | chilling;
    locked      = !running && (elapsed_inc < recovery_length);
    start       = !running && !locked && req.safe_to_run && req.temp_valid;
    heat_start  = start && (temp_x < lo_bound);
    chill_start = start && !heat_start && (temp_x > hi_bound);

    heating_next         = heating;
    chilling_next        = chilling;
    pulse_length_next    = pulse_length;
    recovery_length_next = recovery_length;
    elapsed_ms_next      = elapsed_inc;
    quiet_pending_next   = quiet_pending;

    priority if (heat_start) begin
      heating_next         = 1'b1;
      chilling_next        = 1'b0;
      pulse_length_next    = heat_pulse_ms;
      recovery_length_next = heat_recovery_ms;
      elapsed_ms_next      = '0;
      quiet_pending_next   = 1'b0;
    end else if (chill_start) begin
      heating_next         = 1'b0;
      chilling_next        = 1'b1;
      pulse_length_next    = chill_pulse_ms;
      recovery_length_next = chill_recovery_ms;
      elapsed_ms_next      = '0;
      quiet_pending_next   = 1'b0;
    end else begin
    end

    stop = (heating_next | chilling_next)
         && (!req.safe_to_run || (elapsed_ms_next >= pulse_length_next));
    if (stop) begin
      heating_next    = 1'b0;
      chilling_next   = 1'b0;
      elapsed_ms_next = '0;
    end

    priority if (heating_next) begin
      rsp.mode = phct_pkg::MODE_HEAT;
    end else if (chilling_next) begin
      rsp.mode = phct_pkg::MODE_CHILL;
    end else if (elapsed_ms_next < recovery_length_next) begin
      rsp.mode = phct_pkg::MODE_LOCKOUT;
    end else begin
      rsp.mode = phct_pkg::MODE_IDLE;
    end
    rsp.heater_drive  = heating_next && (32'(pwm_phase_next) < 32'(heat_power_pct));
    rsp.chiller_drive = chilling_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint          <= phct_pkg::SETPOINT_RST;
      tolerance         <= phct_pkg::TOLERANCE_RST;
      heat_power_pct    <= phct_pkg::HEAT_PCT_RST;
      heat_pulse_ms     <= phct_pkg::HEAT_PULSE_RST;
      heat_recovery_ms  <= phct_pkg::HEAT_RECOV_RST;
      chill_pulse_ms    <= phct_pkg::CHILL_PULSE_RST;
      chill_recovery_ms <= phct_pkg::CHILL_RECOV_RST;
      heating           <= 1'b0;
      chilling          <= 1'b0;
      pulse_length      <= '0;
      recovery_length   <= phct_pkg::QUIET_RST;
      elapsed_ms        <= '0;
      pwm_phase         <= '0;
      quiet_pending     <= 1'b1;
    end else if (step) begin
      heating         <= heating_next;
      chilling        <= chilling_next;
      pulse_length    <= pulse_length_next;
      recovery_length <= recovery_length_next;
      elapsed_ms      <= elapsed_ms_next;
      pwm_phase       <= pwm_phase_next;
      quiet_pending   <= quiet_pending_next;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        phct_pkg::REG_SETPOINT:          setpoint <= $signed(cfg_data[phct_pkg::TEMP_W-1:0]);
        phct_pkg::REG_TOLERANCE:         tolerance <= cfg_data[phct_pkg::TOL_W-1:0];
        phct_pkg::REG_HEAT_POWER_PCT:    heat_power_pct <= cfg_data[phct_pkg::PCT_W-1:0];
        phct_pkg::REG_HEAT_PULSE_MS:     heat_pulse_ms <= cfg_data;
        phct_pkg::REG_HEAT_RECOVERY_MS:  heat_recovery_ms <= cfg_data;
        phct_pkg::REG_CHILL_PULSE_MS:    chill_pulse_ms <= cfg_data;
        phct_pkg::REG_CHILL_RECOVERY_MS: chill_recovery_ms <= cfg_data;
        phct_pkg::REG_INITIAL_QUIET_MS: begin
          if (quiet_pending) begin
            recovery_length <= cfg_data;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pulsed_heat_chill_thermostat.sv =====
// ----------------------------------------------------------------------------
// pulsed_heat_chill_thermostat
// Bang-bang heat/chill controller with post-pulse lockout and heater PWM.
// ----------------------------------------------------------------------------
// Each request is one 1 ms tick carrying a temperature sample; each yields
// exactly one response with the heater and chiller levels and the mode. The
// block takes one request per clock cycle, held back only by reset or a
// stalled response register: a request is registered in the input register,
// and the thermostat state updates in a single pass as it moves to the
// response register. Write configuration only with no request or response
// in flight.
`default_nettype none

module pulsed_heat_chill_thermostat (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire phct_pkg::req_t                   req,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output phct_pkg::rsp_t                        rsp,
  input  wire logic                             cfg_we,
  input  wire logic [phct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [phct_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic            hold_valid;
  phct_pkg::req_t  hold;
  logic            advance;
  phct_pkg::rsp_t  rsp_next;

  assign advance   = hold_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !rst && (!hold_valid || advance);

  phct_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .req       (hold),
    .rsp       (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold <= req;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/phct_checker.sv =====
// ----------------------------------------------------------------------------
// phct_checker
// Port-level checks on the thermostat, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module phct_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            req_valid,
  input wire logic            req_ready,
  input wire logic            rsp_valid,
  input wire logic            rsp_ready,
  input wire phct_pkg::rsp_t  rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_heater_mode: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.heater_drive |-> rsp.mode == phct_pkg::MODE_HEAT)
    else $error("heater driven outside heating mode");

  a_chiller_mode: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.chiller_drive == (rsp.mode == phct_pkg::MODE_CHILL))
    else $error("chiller level disagrees with mode");

  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
    else $error("response without a request");

endmodule

bind pulsed_heat_chill_thermostat phct_checker u_phct_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
